// File: design/dpcs_pkg.sv
// Package for the drive poll and command sequencer: command and frame constants,
// the microcode word and its program table, and the frame byte builder.
// No dependencies; the top level and the sequencer import it.
`default_nettype none

package dpcs_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ENQUEUE = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;

    // Command codes.
    localparam logic [3:0] CMD_STATUS    = 4'd1;
    localparam logic [3:0] CMD_START     = 4'd2;
    localparam logic [3:0] CMD_STOP      = 4'd3;
    localparam logic [3:0] CMD_SET_SPEED = 4'd4;
    localparam logic [3:0] CMD_GET_SPEED = 4'd5;
    localparam logic [3:0] CMD_FAULTS    = 4'd6;
    localparam logic [3:0] CMD_REMOTE    = 4'd7;
    localparam logic [3:0] CMD_BUTTON    = 4'd8;

    // Configuration register indexes.
    localparam logic CFG_REVERSE = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Frame bytes.
    localparam logic [7:0] DRIVE_ADDR   = 8'd100;
    localparam logic [7:0] FN_READ      = 8'd3;
    localparam logic [7:0] FN_WRITE     = 8'd6;
    localparam logic [7:0] FN_BUTTON    = 8'd1;
    localparam logic [7:0] REG_CTRL_HI  = 8'h20;
    localparam logic [7:0] REG_STAT_HI  = 8'h21;
    localparam logic [7:0] REG_MODE_HI  = 8'h00;
    localparam logic [7:0] REG_LO_ZERO  = 8'h00;
    localparam logic [7:0] REG_LO_ONE   = 8'h01;
    localparam logic [7:0] REG_MODE_LO  = 8'd36;
    localparam logic [7:0] DATA_FWD     = 8'h12;
    localparam logic [7:0] DATA_REV     = 8'h22;
    localparam logic [7:0] DATA_STOP    = 8'h01;
    localparam logic [7:0] DATA_REMOTE  = 8'd5;
    localparam logic [7:0] DATA_BUTTON  = 8'd1;

    localparam logic [2:0] LAST_IDX_READ  = 3'd3;
    localparam logic [2:0] LAST_IDX_WRITE = 3'd5;

    // Reset values and limits.
    localparam logic [7:0]  WAIT_CAP       = 8'd200;
    localparam logic [7:0]  TIMEOUT_RESET  = 8'd10;
    localparam logic [15:0] SETPOINT_RESET = 16'd500;

    // Microcode.
    typedef logic [3:0] step_t;

    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_TICK     = 4'd1;
    localparam step_t S_TICK_CHK = 4'd2;
    localparam step_t S_POLL     = 4'd3;
    localparam step_t S_ENQ_CHK  = 4'd4;
    localparam step_t S_ENQ      = 4'd5;
    localparam step_t S_SEND_CHK = 4'd6;
    localparam step_t S_POP      = 4'd7;
    localparam step_t S_EMIT     = 4'd8;
    localparam step_t S_REPLY    = 4'd9;
    localparam step_t S_SNAP     = 4'd10;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_TICK      = 4'd1,
        ACT_POLL      = 4'd2,
        ACT_ENQUEUE   = 4'd3,
        ACT_POP       = 4'd4,
        ACT_EMIT_BYTE = 4'd5,
        ACT_DECODE    = 4'd6,
        ACT_EMIT_SNAP = 4'd7
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS     = 3'd0,
        C_DISPATCH   = 3'd1,
        C_AWAITING   = 3'd2,
        C_BAD_CODE   = 3'd3,
        C_NO_SEND    = 3'd4,
        C_MORE_BYTES = 3'd5
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  emits;
        step_t tgt_true;
        step_t tgt_false;
    } uword_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic       item_fire;
        logic [1:0] op;
        logic       awaiting;
        logic       bad_code;
        logic       no_send;
        logic       more_bytes;
        logic       out_free;
    } seq_status_t;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        act_t act;
        logic idle;
    } seq_ctl_t;

    // The program. A taken condition goes to tgt_true, otherwise to tgt_false.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        begin
            w = '{ACT_NONE, C_DISPATCH, 1'b0, S_IDLE, S_IDLE};
            case (s)
                S_IDLE:     w = '{ACT_NONE, C_DISPATCH, 1'b0, S_IDLE, S_IDLE};
                S_TICK:     w = '{ACT_TICK, C_ALWAYS, 1'b0, S_TICK_CHK, S_TICK_CHK};
                S_TICK_CHK: w = '{ACT_NONE, C_AWAITING, 1'b0, S_IDLE, S_POLL};
                S_POLL:     w = '{ACT_POLL, C_ALWAYS, 1'b0, S_SEND_CHK, S_SEND_CHK};
                S_ENQ_CHK:  w = '{ACT_NONE, C_BAD_CODE, 1'b0, S_IDLE, S_ENQ};
                S_ENQ:      w = '{ACT_ENQUEUE, C_ALWAYS, 1'b0, S_SEND_CHK, S_SEND_CHK};
                S_SEND_CHK: w = '{ACT_NONE, C_NO_SEND, 1'b0, S_IDLE, S_POP};
                S_POP:      w = '{ACT_POP, C_ALWAYS, 1'b0, S_EMIT, S_EMIT};
                S_EMIT:     w = '{ACT_EMIT_BYTE, C_MORE_BYTES, 1'b1, S_EMIT, S_IDLE};
                S_REPLY:    w = '{ACT_DECODE, C_ALWAYS, 1'b0, S_SNAP, S_SNAP};
                S_SNAP:     w = '{ACT_EMIT_SNAP, C_ALWAYS, 1'b1, S_IDLE, S_IDLE};
                default:    w = '{ACT_NONE, C_DISPATCH, 1'b0, S_IDLE, S_IDLE};
            endcase
            return w;
        end
    endfunction

    // Index of the final byte of the frame for a command.
    function automatic logic [2:0] frame_last_idx(input logic [3:0] code);
        logic [2:0] n;
        begin
            n = LAST_IDX_WRITE;
            if (code == CMD_STATUS || code == CMD_GET_SPEED || code == CMD_FAULTS)
            begin
                n = LAST_IDX_READ;
            end
            return n;
        end
    endfunction

    // One byte of the frame for a command.
    function automatic logic [7:0] frame_byte_of(
        input logic [3:0]  code,
        input logic [2:0]  idx,
        input logic        rev,
        input logic [15:0] setpoint
    );
        logic [7:0] fn;
        logic [7:0] rhi;
        logic [7:0] rlo;
        logic [7:0] dhi;
        logic [7:0] dlo;
        logic [7:0] b;
        begin
            dhi = 8'h00;
            dlo = 8'h00;
            case (code)
                CMD_STATUS:
                begin
                    fn = FN_READ;  rhi = REG_STAT_HI; rlo = REG_LO_ZERO;
                end
                CMD_START:
                begin
                    fn = FN_WRITE; rhi = REG_CTRL_HI; rlo = REG_LO_ZERO;
                    dlo = rev ? DATA_REV : DATA_FWD;
                end
                CMD_STOP:
                begin
                    fn = FN_WRITE; rhi = REG_CTRL_HI; rlo = REG_LO_ZERO;
                    dlo = DATA_STOP;
                end
                CMD_SET_SPEED:
                begin
                    fn = FN_WRITE; rhi = REG_CTRL_HI; rlo = REG_LO_ONE;
                    dhi = setpoint[15:8];
                    dlo = setpoint[7:0];
                end
                CMD_GET_SPEED:
                begin
                    fn = FN_READ;  rhi = REG_CTRL_HI; rlo = REG_LO_ONE;
                end
                CMD_FAULTS:
                begin
                    fn = FN_READ;  rhi = REG_STAT_HI; rlo = REG_LO_ONE;
                end
                CMD_REMOTE:
                begin
                    fn = FN_WRITE; rhi = REG_MODE_HI; rlo = REG_MODE_LO;
                    dlo = DATA_REMOTE;
                end
                default:
                begin
                    fn = FN_BUTTON; rhi = REG_MODE_HI; rlo = REG_MODE_LO;
                    dlo = DATA_BUTTON;
                end
            endcase
            case (idx)
                3'd0:    b = DRIVE_ADDR;
                3'd1:    b = fn;
                3'd2:    b = rhi;
                3'd3:    b = rlo;
                3'd4:    b = dhi;
                default: b = dlo;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/dpcs_if.sv
// Handshake channels of the drive poll and command sequencer: the input item
// channel and the result channel. No dependencies.
`default_nettype none

interface dpcs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  command_code;
    logic [15:0] speed_value;
    logic [6:0]  reply_count;
    logic [7:0]  reply_low;
    logic [7:0]  reply_high;

    modport source (
        output valid, operation, command_code, speed_value,
               reply_count, reply_low, reply_high,
        input  ready
    );
    modport sink (
        input  valid, operation, command_code, speed_value,
               reply_count, reply_low, reply_high,
        output ready
    );
endinterface

interface dpcs_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  frame_byte;
    logic        last;
    logic [15:0] status_word;
    logic [15:0] fault_word;
    logic [15:0] speed_reading;
    logic        device_seen;
    logic        comm_lost;

    modport source (
        output valid, kind, frame_byte, last, status_word, fault_word,
               speed_reading, device_seen, comm_lost,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_byte, last, status_word, fault_word,
               speed_reading, device_seen, comm_lost,
        output ready
    );
endinterface

`default_nettype wire

// File: design/drive_poll_command_sequencer.sv
// Top level of the drive poll and command sequencer: command queue, reply
// timer, decoded words and output register around the microcode sequencer.
// Depends on dpcs_pkg, dpcs_if.sv (channel interfaces) and dpcs_seq.
//
//   Channel   Dir   Handshake      Moves
//   item      in    valid/ready    tick, enqueue command, or received reply
//   result    out   valid/ready    one frame byte, or one reply snapshot
//   cfg       in    cfg_we only    reverse_direction (0), timeout_ticks (1)
//
// Steps: an item is taken in the idle step. A reply is latched, decoded and
// snapshotted. An enqueue that sends runs the code check, enqueue, send check,
// pop and one emit step per frame byte (4 or 6); a tick that polls and sends
// runs tick, tick check, poll, send check, pop and the emit steps. The order is
// set by the microcode program, which runs one step per cycle when not stalled, for one item at a time.
// Reset is asynchronous and active low and needs no clearing pass.
// A stalled result channel holds the sequencer on its output step only.
`default_nettype none

module drive_poll_command_sequencer
    import dpcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    dpcs_item_if.sink       item,
    dpcs_result_if.source   result,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration.
    logic        reverse_reg;
    logic [7:0]  timeout_reg;

    // Latched input item.
    logic [3:0]  code_reg;
    logic [15:0] spd_in_reg;
    logic [6:0]  count_reg;
    logic [15:0] word_reg;

    // Command queue: entry 0 is the head; fill_reg counts the held commands.
    logic [3:0]        queue_reg [QUEUE_DEPTH];
    logic [FILL_W-1:0] fill_reg;

    // Link and poll state.
    logic        awaiting_reg;
    logic [7:0]  wait_reg;
    logic [1:0]  phase_reg;
    logic [3:0]  last_sent_reg;
    logic [15:0] setpoint_reg;
    logic [15:0] status_reg;
    logic [15:0] fault_reg;
    logic [15:0] speed_reg;
    logic        seen_reg;
    logic        lost_reg;

    // Frame being sent.
    logic [3:0]  frame_code_reg;
    logic [2:0]  byte_idx_reg;

    // Output register.
    logic        res_valid_reg;
    logic        res_kind_reg;
    logic [7:0]  res_byte_reg;
    logic        res_last_reg;
    logic [15:0] res_status_reg;
    logic [15:0] res_fault_reg;
    logic [15:0] res_speed_reg;
    logic        res_seen_reg;
    logic        res_lost_reg;

    seq_status_t st;
    seq_ctl_t    ctl;

    logic        item_fire;
    logic        out_free;
    logic        queue_empty;
    logic        enq_en;
    logic [3:0]  enq_code;
    logic [7:0]  wait_inc;
    logic        timeout_hit;
    logic        read_hit;
    logic [2:0]  last_idx;
    logic [1:0]  phase_next;

    assign item_fire   = item.valid && item.ready;
    assign item.ready  = ctl.idle;
    assign out_free    = !res_valid_reg || result.ready;
    assign queue_empty = (fill_reg == '0);
    assign last_idx    = frame_last_idx(frame_code_reg);

    // The reply timer saturates at its cap; the wait ends once it reaches the
    // configured timeout, so a timeout of zero ends it on the first tick.
    assign wait_inc    = (wait_reg < WAIT_CAP) ? (wait_reg + 8'd1) : wait_reg;
    assign timeout_hit = (wait_inc >= timeout_reg);

    // Only a reply to a read command with at least two bytes is decoded.
    assign read_hit = (count_reg > 7'd1) &&
                      (last_sent_reg == CMD_STATUS || last_sent_reg == CMD_GET_SPEED ||
                       last_sent_reg == CMD_FAULTS);

    always_comb
    begin
        st.item_fire  = item_fire;
        st.op         = item.operation;
        st.awaiting   = awaiting_reg;
        st.bad_code   = !(code_reg inside {[CMD_STATUS:CMD_BUTTON]});
        st.no_send    = awaiting_reg || queue_empty;
        st.more_bytes = (byte_idx_reg != last_idx);
        st.out_free   = out_free;
    end

    dpcs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (st),
        .ctl    (ctl)
    );

    // Polling rotates speed, status, faults; the phase after a speed poll is
    // one, and any phase other than one or two polls speed.
    always_comb
    begin
        enq_en     = 1'b0;
        enq_code   = code_reg;
        phase_next = 2'd1;
        case (phase_reg)
            2'd1:    phase_next = 2'd2;
            2'd2:    phase_next = 2'd3;
            default: phase_next = 2'd1;
        endcase
        if (ctl.act == ACT_ENQUEUE)
        begin
            enq_en = 1'b1;
        end
        else if (ctl.act == ACT_POLL && queue_empty)
        begin
            enq_en = 1'b1;
            case (phase_reg)
                2'd1:    enq_code = CMD_STATUS;
                2'd2:    enq_code = CMD_FAULTS;
                default: enq_code = CMD_GET_SPEED;
            endcase
        end
    end

    // Queue storage; a full queue drops the new command.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (ctl.act == ACT_POP)
            begin
                if (i + 1 < QUEUE_DEPTH)
                begin
                    queue_reg[i] <= queue_reg[i + 1];
                end
            end
            else if (enq_en && fill_reg == FILL_W'(i))
            begin
                queue_reg[i] <= enq_code;
            end
        end
    end

    // Item latch and frame registers.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            code_reg   <= item.command_code;
            spd_in_reg <= item.speed_value;
            count_reg  <= item.reply_count;
            word_reg   <= {item.reply_high, item.reply_low};
        end
        if (ctl.act == ACT_POP)
        begin
            frame_code_reg <= queue_reg[0];
            byte_idx_reg   <= 3'd0;
        end
        else if (ctl.act == ACT_EMIT_BYTE)
        begin
            byte_idx_reg <= byte_idx_reg + 3'd1;
        end
    end

    // Control and held state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg   <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            fill_reg      <= '0;
            awaiting_reg  <= 1'b0;
            wait_reg      <= 8'd0;
            phase_reg     <= 2'd0;
            last_sent_reg <= 4'd0;
            setpoint_reg  <= SETPOINT_RESET;
            status_reg    <= 16'd0;
            fault_reg     <= 16'd0;
            speed_reg     <= 16'd0;
            seen_reg      <= 1'b0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REVERSE: reverse_reg <= cfg_data[0];
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default:     timeout_reg <= timeout_reg;
                endcase
            end

            if (ctl.act == ACT_POP)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
            else if (enq_en && fill_reg < FILL_W'(QUEUE_DEPTH))
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end

            case (ctl.act)
                ACT_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        if (timeout_hit)
                        begin
                            awaiting_reg <= 1'b0;
                            wait_reg     <= 8'd0;
                            lost_reg     <= 1'b1;
                        end
                        else
                        begin
                            wait_reg <= wait_inc;
                        end
                    end
                end
                ACT_POLL:
                begin
                    if (queue_empty)
                    begin
                        phase_reg <= phase_next;
                    end
                end
                ACT_ENQUEUE:
                begin
                    if (code_reg == CMD_SET_SPEED)
                    begin
                        setpoint_reg <= spd_in_reg;
                    end
                end
                ACT_POP:
                begin
                    last_sent_reg <= queue_reg[0];
                    awaiting_reg  <= 1'b1;
                    wait_reg      <= 8'd0;
                end
                ACT_DECODE:
                begin
                    awaiting_reg <= 1'b0;
                    if (read_hit)
                    begin
                        case (last_sent_reg)
                            CMD_STATUS: status_reg <= word_reg;
                            CMD_FAULTS: fault_reg  <= word_reg;
                            default:    speed_reg  <= word_reg;
                        endcase
                        seen_reg <= 1'b1;
                        lost_reg <= 1'b0;
                    end
                end
                default:
                begin
                    lost_reg <= lost_reg;
                end
            endcase
        end
    end

    // Output register: a new result loads only when the slot is free, which
    // the sequencer guarantees by holding its output steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.act == ACT_EMIT_BYTE || ctl.act == ACT_EMIT_SNAP)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.act == ACT_EMIT_BYTE)
        begin
            res_kind_reg   <= 1'b0;
            res_byte_reg   <= frame_byte_of(frame_code_reg, byte_idx_reg,
                                            reverse_reg, setpoint_reg);
            res_last_reg   <= (byte_idx_reg == last_idx);
            res_status_reg <= 16'd0;
            res_fault_reg  <= 16'd0;
            res_speed_reg  <= 16'd0;
            res_seen_reg   <= 1'b0;
            res_lost_reg   <= 1'b0;
        end
        else if (ctl.act == ACT_EMIT_SNAP)
        begin
            res_kind_reg   <= 1'b1;
            res_byte_reg   <= 8'd0;
            res_last_reg   <= 1'b1;
            res_status_reg <= status_reg;
            res_fault_reg  <= fault_reg;
            res_speed_reg  <= speed_reg;
            res_seen_reg   <= seen_reg;
            res_lost_reg   <= lost_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.kind          = res_kind_reg;
    assign result.frame_byte    = res_byte_reg;
    assign result.last          = res_last_reg;
    assign result.status_word   = res_status_reg;
    assign result.fault_word    = res_fault_reg;
    assign result.speed_reading = res_speed_reg;
    assign result.device_seen   = res_seen_reg;
    assign result.comm_lost     = res_lost_reg;

`ifndef SYNTH
    // Sending a frame always opens a fresh reply wait.
    a_pop_arms_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_POP) |=> (awaiting_reg && wait_reg == 8'd0))
        else $error("frame sent without arming the reply wait");

    // A decoded reply always ends the wait.
    a_reply_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_DECODE) |=> !awaiting_reg)
        else $error("reply left the wait armed");

    // The queue never holds more commands than it has entries.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        enq_en |=> (fill_reg <= FILL_W'(QUEUE_DEPTH)))
        else $error("command queue overfilled");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |-> (ctl.act != ACT_EMIT_BYTE &&
                                              ctl.act != ACT_EMIT_SNAP))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// File: design/dpcs_seq.sv
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on dpcs_pkg.
`default_nettype none

module dpcs_seq
    import dpcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire seq_status_t status,
    output seq_ctl_t         ctl
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uword;
    logic   stall;
    logic   taken;
    step_t  entry;

    assign uword = ucode(step_reg);

    // A step that produces a result waits until the output register can take it.
    assign stall = uword.emits && !status.out_free;

    always_comb
    begin
        case (status.op)
            OP_TICK:    entry = S_TICK;
            OP_ENQUEUE: entry = S_ENQ_CHK;
            OP_REPLY:   entry = S_REPLY;
            default:    entry = S_IDLE;
        endcase
    end

    always_comb
    begin
        case (uword.cond)
            C_ALWAYS:     taken = 1'b1;
            C_DISPATCH:   taken = status.item_fire;
            C_AWAITING:   taken = status.awaiting;
            C_BAD_CODE:   taken = status.bad_code;
            C_NO_SEND:    taken = status.no_send;
            C_MORE_BYTES: taken = status.more_bytes;
            default:      taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (uword.cond == C_DISPATCH)
        begin
            step_next = status.item_fire ? entry : S_IDLE;
        end
        else
        begin
            step_next = taken ? uword.tgt_true : uword.tgt_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl.act  = stall ? ACT_NONE : uword.act;
    assign ctl.idle = (step_reg == S_IDLE);

endmodule

`default_nettype wire
